// ===== rtl/core/fmsl_pkg.sv =====
package fmsl_pkg;

    localparam int MAX_PARTICLES = 4096;
    localparam int WORD_BITS     = 32;
    localparam int NUM_WORDS     = (MAX_PARTICLES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW       = $clog2(NUM_WORDS);
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int LIST_AW       = $clog2(MAX_PARTICLES);
    localparam int COUNT_W       = LIST_AW + 1;

    localparam int FUNC_W        = 2;
    localparam int PART_W        = 12;
    localparam int SLOT_W        = 12;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_TEST   = 2'd0,
        FN_ADD    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] wdata;
    } bm_req_t;

endpackage

// ===== rtl/core/fmsl_ram.sv =====
module fmsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fmsl_bitmap.sv =====
module fmsl_bitmap (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fmsl_pkg::bm_req_t              req,
    output logic [fmsl_pkg::WORD_BITS-1:0] word
);
    import fmsl_pkg::*;

    logic [NUM_WORDS-1:0] valid_reg;
    logic                 hit_reg;
    logic [WORD_BITS-1:0] ram_q;

    // word never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else if (req.en)
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            else
            begin
                hit_reg <= valid_reg[req.addr];
            end
        end
    end

    fmsl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (req.en),
        .we    (req.we),
        .addr  (req.addr),
        .wdata (req.wdata),
        .rdata (ram_q)
    );

    assign word = hit_reg ? ram_q : '0;

endmodule

// ===== rtl/core/fixed_member_set_with_list.sv =====
// channel | fields (lowest bit first)                              | handshake
// s       | tuser: func[1:0]; tdata: particle[11:0], slot[23:12]   | s_tvalid/s_tready
// m       | tdata: was_member[0], member_count[13:1],              | m_tvalid/m_tready
//         |        slot_particle[25:14], slot_valid[26]            |
// Test, add, read and remove of a non-member: S_BIT (S_RDL for read), then S_OUT.
// Remove of a member goes on from S_BIT to S_SCAN, which scans the list one entry per
// cycle through the single list memory port; S_MOVE then moves the last entry into the hole.
// Reset clears the count and the per-word valid bits of the bitmap; no clearing pass.
// A finished result waits in the output register while the next request is taken.
module fixed_member_set_with_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fmsl_pkg::FUNC_W-1:0]     s_tuser,   // func
    input  logic [fmsl_pkg::IN_DATA_W-1:0]  s_tdata,   // particle, slot
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fmsl_pkg::OUT_DATA_W-1:0] m_tdata    // was_member, member_count,
                                                       // slot_particle, slot_valid
);
    import fmsl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDL,
        S_BIT,
        S_SCAN,
        S_MOVE,
        S_OUT
    } state_t;

    state_t                state_reg;
    func_t                 func_reg;
    logic [PART_W-1:0]     part_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  was_reg;
    logic [PART_W-1:0]     sp_reg;
    logic                  sv_reg;
    logic [LIST_AW-1:0]    scan_idx_reg;
    logic [LIST_AW-1:0]    hole_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic                  accept;
    func_t                 in_func;
    logic [PART_W-1:0]     in_part;
    logic [SLOT_W-1:0]     in_slot;
    logic                  slot_ok;
    logic                  out_load;

    bm_req_t               bm_req;
    logic [WORD_BITS-1:0]  bm_word;
    logic [BIT_W-1:0]      bit_idx;
    logic [WORD_BITS-1:0]  bit_mask;
    logic                  cur_bit;
    logic                  add_go;
    logic                  rem_go;

    logic                  l_en;
    logic                  l_we;
    logic [LIST_AW-1:0]    l_addr;
    logic [PART_W-1:0]     l_wdata;
    logic [PART_W-1:0]     l_rdata;
    logic                  match;
    logic                  scan_last;
    logic [LIST_AW-1:0]    last_idx;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_func  = func_t'(s_tuser);
    assign in_part  = s_tdata[PART_W-1:0];
    assign in_slot  = s_tdata[PART_W+SLOT_W-1:PART_W];
    assign slot_ok  = (COUNT_W'(in_slot) < count_reg);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign bit_idx  = part_reg[BIT_W-1:0];
    assign bit_mask = WORD_BITS'(1) << bit_idx;
    assign cur_bit  = bm_word[bit_idx];
    assign add_go   = (func_reg == FN_ADD) && !cur_bit
                      && (count_reg < COUNT_W'(MAX_PARTICLES));
    assign rem_go   = (func_reg == FN_REMOVE) && cur_bit;

    assign match     = (l_rdata == part_reg);
    assign scan_last = ((COUNT_W'(scan_idx_reg) + COUNT_W'(1)) >= count_reg);
    assign last_idx  = LIST_AW'(count_reg - COUNT_W'(1));

    always_comb
    begin
        bm_req = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_func != FN_READ))
                begin
                    bm_req.en   = 1'b1;
                    bm_req.addr = WORD_AW'(in_part >> BIT_W);
                end
            end
            S_BIT:
            begin
                if (add_go || rem_go)
                begin
                    bm_req.en    = 1'b1;
                    bm_req.we    = 1'b1;
                    bm_req.addr  = WORD_AW'(part_reg >> BIT_W);
                    bm_req.wdata = add_go ? (bm_word | bit_mask) : (bm_word & ~bit_mask);
                end
            end
            default:
            begin
                bm_req = '0;
            end
        endcase
    end

    always_comb
    begin
        l_en    = 1'b0;
        l_we    = 1'b0;
        l_addr  = '0;
        l_wdata = part_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_func == FN_READ))
                begin
                    l_en   = 1'b1;
                    l_addr = LIST_AW'(in_slot);
                end
            end
            S_BIT:
            begin
                if (add_go)
                begin
                    l_en   = 1'b1;
                    l_we   = 1'b1;
                    l_addr = count_reg[LIST_AW-1:0];
                end
                else if (rem_go)
                begin
                    l_en   = 1'b1;
                    l_addr = '0;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    l_en   = 1'b1;
                    l_addr = last_idx;
                end
                else if (!scan_last)
                begin
                    l_en   = 1'b1;
                    l_addr = scan_idx_reg + LIST_AW'(1);
                end
            end
            S_MOVE:
            begin
                l_en    = 1'b1;
                l_we    = 1'b1;
                l_addr  = hole_reg;
                l_wdata = l_rdata;
            end
            default:
            begin
                l_en = 1'b0;
            end
        endcase
    end

    fmsl_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bm_req),
        .word  (bm_word)
    );

    fmsl_ram #(
        .WIDTH (PART_W),
        .DEPTH (MAX_PARTICLES)
    ) u_list (
        .clk   (clk),
        .en    (l_en),
        .we    (l_we),
        .addr  (l_addr),
        .wdata (l_wdata),
        .rdata (l_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= in_func;
                        part_reg  <= in_part;
                        sv_reg    <= (in_func == FN_READ) && slot_ok;
                        state_reg <= (in_func == FN_READ) ? S_RDL : S_BIT;
                    end
                end
                S_RDL:
                begin
                    was_reg   <= 1'b0;
                    sp_reg    <= sv_reg ? l_rdata : '0;
                    state_reg <= S_OUT;
                end
                S_BIT:
                begin
                    was_reg <= cur_bit;
                    sp_reg  <= '0;
                    if (add_go)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    if (rem_go)
                    begin
                        scan_idx_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        hole_reg  <= scan_idx_reg;
                        state_reg <= S_MOVE;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + LIST_AW'(1);
                    end
                end
                S_MOVE:
                begin
                    count_reg <= count_reg - COUNT_W'(1);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= OUT_DATA_W'({sv_reg, sp_reg, count_reg, was_reg});
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_PARTICLES))
        else $error("member count beyond capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while another is in progress");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg))
        |-> ($past(state_reg) == S_BIT || $past(state_reg) == S_MOVE))
        else $error("count changed outside add or move");

    a_read_not_member: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[27 - 1]) |-> !m_tdata[0])
        else $error("valid slot read reports membership");

endmodule

// ===== dv/fixed_member_set_with_list_tb.sv =====
`timescale 1ns / 100ps

module fixed_member_set_with_list_tb;

    import fmsl_pkg::*;

    localparam int NUM_RANDOM   = 450;
    localparam int NUM_DIRECTED = 24;
    localparam int POOL_SIZE    = 128;
    localparam int DRAIN_CYCLES = 32;
    localparam longint CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic               was_member;
        logic [COUNT_W-1:0] member_count;
        logic [PART_W-1:0]  slot_particle;
        logic               slot_valid;
    } outcome_t;

    typedef struct packed {
        func_t             func;
        logic [PART_W-1:0] particle;
        logic [SLOT_W-1:0] slot;
        logic              typed;
        outcome_t          want;
    } vector_t;

    localparam vector_t DIRECTED [NUM_DIRECTED] = '{
        '{FN_READ,   12'd0,    12'd0,    1'b1, '{1'b0, 13'd0, 12'd0,    1'b0}},
        '{FN_TEST,   12'd0,    12'hFFF,  1'b1, '{1'b0, 13'd0, 12'd0,    1'b0}},
        '{FN_REMOVE, 12'hFFF,  12'd0,    1'b1, '{1'b0, 13'd0, 12'd0,    1'b0}},
        '{FN_ADD,    12'd0,    12'd0,    1'b1, '{1'b0, 13'd1, 12'd0,    1'b0}},
        '{FN_ADD,    12'hFFF,  12'd0,    1'b1, '{1'b0, 13'd2, 12'd0,    1'b0}},
        '{FN_ADD,    12'hFFF,  12'd0,    1'b1, '{1'b1, 13'd2, 12'd0,    1'b0}},
        '{FN_TEST,   12'hFFF,  12'd0,    1'b1, '{1'b1, 13'd2, 12'd0,    1'b0}},
        '{FN_READ,   12'hFFF,  12'd0,    1'b1, '{1'b0, 13'd2, 12'd0,    1'b1}},
        '{FN_READ,   12'd0,    12'd1,    1'b1, '{1'b0, 13'd2, 12'hFFF,  1'b1}},
        '{FN_READ,   12'd0,    12'd2,    1'b1, '{1'b0, 13'd2, 12'd0,    1'b0}},
        '{FN_READ,   12'd0,    12'hFFF,  1'b1, '{1'b0, 13'd2, 12'd0,    1'b0}},
        '{FN_ADD,    12'd31,   12'd0,    1'b0, '0},
        '{FN_ADD,    12'd32,   12'd0,    1'b0, '0},
        '{FN_ADD,    12'hAAA,  12'h555,  1'b0, '0},
        '{FN_ADD,    12'h555,  12'hAAA,  1'b0, '0},
        '{FN_REMOVE, 12'd0,    12'd0,    1'b0, '0},
        '{FN_REMOVE, 12'h555,  12'd0,    1'b0, '0},
        '{FN_REMOVE, 12'hFFF,  12'd0,    1'b0, '0},
        '{FN_REMOVE, 12'hFFF,  12'd0,    1'b0, '0},
        '{FN_TEST,   12'd31,   12'd0,    1'b0, '0},
        '{FN_READ,   12'd0,    12'd0,    1'b0, '0},
        '{FN_READ,   12'd0,    12'd1,    1'b0, '0},
        '{FN_READ,   12'd0,    12'd2,    1'b0, '0},
        '{FN_READ,   12'd0,    12'd3,    1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [FUNC_W-1:0]     s_tuser;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [WORD_BITS-1:0] set_bitmap [NUM_WORDS];
    logic [PART_W-1:0]    set_list   [MAX_PARTICLES];
    logic [COUNT_W-1:0]   set_count;
    logic [PART_W-1:0]    particle_pool [POOL_SIZE];

    outcome_t pending_outcomes [$];
    int       errors = 0;
    longint   cycles = 0;
    bit       sender_burst;
    bit       receiver_burst;

    fixed_member_set_with_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fixed_member_set_with_list_tb: FAIL");
            $finish;
        end
    end

    function automatic outcome_t apply_op(func_t f, logic [PART_W-1:0] p,
                                          logic [SLOT_W-1:0] s);
        outcome_t           o;
        int                 i;
        logic [WORD_AW-1:0] w;
        logic [BIT_W-1:0]   b;
        o = '0;
        w = p[PART_W-1:BIT_W];
        b = p[BIT_W-1:0];
        if (f == FN_READ)
        begin
            if (s < set_count)
            begin
                o.slot_valid    = 1'b1;
                o.slot_particle = set_list[s];
            end
        end
        else
        begin
            o.was_member = set_bitmap[w][b];
            if (f == FN_ADD && !o.was_member && set_count < MAX_PARTICLES)
            begin
                set_bitmap[w][b] = 1'b1;
                set_list[set_count[LIST_AW-1:0]] = p;
                set_count = set_count + 1'b1;
            end
            else if (f == FN_REMOVE && o.was_member)
            begin
                set_bitmap[w][b] = 1'b0;
                i = 0;
                while (i < set_count && set_list[i] != p)
                    i++;
                if (i < set_count)
                begin
                    set_list[i] = set_list[LIST_AW'(set_count - 1'b1)];
                    set_count = set_count - 1'b1;
                end
            end
        end
        o.member_count = set_count;
        return o;
    endfunction

    function automatic int pick_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 field, cycles, got, want);
        errors++;
    endtask

    task automatic issue_request(func_t f, logic [PART_W-1:0] p, logic [SLOT_W-1:0] s,
                                 logic typed, outcome_t want);
        int       gap;
        outcome_t predicted;
        if ($urandom_range(0, 31) == 0)
            sender_burst = ~sender_burst;
        gap = pick_wait(sender_burst);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {s, p};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_op(f, p, s);
        pending_outcomes = {pending_outcomes, (typed ? want : predicted)};
    endtask

    initial
    begin : receiver
        int       stall;
        outcome_t got;
        outcome_t want;
        m_tready = 1'b0;
        receiver_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                receiver_burst = ~receiver_burst;
            stall = pick_wait(receiver_burst);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.was_member    = m_tdata[0];
            got.member_count  = m_tdata[13:1];
            got.slot_particle = m_tdata[25:14];
            got.slot_valid    = m_tdata[26];
            if (pending_outcomes.size() == 0)
            begin
                $display("unexpected result at cycle %0d: %h", cycles, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.was_member != want.was_member)
                    report_mismatch("was_member", got.was_member, want.was_member);
                if (got.member_count != want.member_count)
                    report_mismatch("member_count", got.member_count, want.member_count);
                if (got.slot_particle != want.slot_particle)
                    report_mismatch("slot_particle", got.slot_particle, want.slot_particle);
                if (got.slot_valid != want.slot_valid)
                    report_mismatch("slot_valid", got.slot_valid, want.slot_valid);
            end
        end
    end

    initial
    begin : stimulus
        int                r;
        int                add_pct;
        int                remove_pct;
        func_t             f;
        logic [PART_W-1:0] p;
        logic [SLOT_W-1:0] s;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = '0;
        s_tdata      = '0;
        sender_burst = 1'b0;
        set_count    = '0;
        for (int w = 0; w < NUM_WORDS; w++)
            set_bitmap[w] = '0;
        for (int k = 0; k < MAX_PARTICLES; k++)
            set_list[k] = '0;
        for (int k = 0; k < POOL_SIZE; k++)
            particle_pool[k] = PART_W'($urandom_range(0, MAX_PARTICLES - 1));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < NUM_DIRECTED; n++)
            issue_request(DIRECTED[n].func, DIRECTED[n].particle, DIRECTED[n].slot,
                          DIRECTED[n].typed, DIRECTED[n].want);

        // grow the set, churn it, then drain it towards empty
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n < NUM_RANDOM / 3)
            begin
                add_pct    = 55;
                remove_pct = 15;
            end
            else if (n < 2 * NUM_RANDOM / 3)
            begin
                add_pct    = 35;
                remove_pct = 30;
            end
            else
            begin
                add_pct    = 15;
                remove_pct = 55;
            end
            r = $urandom_range(0, 99);
            if (r < add_pct)
                f = FN_ADD;
            else if (r < add_pct + remove_pct)
                f = FN_REMOVE;
            else if (r < add_pct + remove_pct + 15)
                f = FN_TEST;
            else
                f = FN_READ;

            if ($urandom_range(0, 9) == 0)
                p = PART_W'($urandom_range(0, MAX_PARTICLES - 1));
            else if (f != FN_ADD && set_count != 0 && $urandom_range(0, 1) == 0)
                p = set_list[$urandom_range(0, set_count - 1)];
            else
                p = particle_pool[$urandom_range(0, POOL_SIZE - 1)];

            if (f == FN_READ && $urandom_range(0, 4) != 0)
                s = SLOT_W'($urandom_range(0, set_count + 1));
            else
                s = SLOT_W'($urandom_range(0, MAX_PARTICLES - 1));

            issue_request(f, p, s, 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("fixed_member_set_with_list_tb: PASS");
        else
            $display("fixed_member_set_with_list_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fmsl_pkg.sv
rtl/core/fmsl_ram.sv
rtl/core/fmsl_bitmap.sv
rtl/core/fixed_member_set_with_list.sv
dv/fixed_member_set_with_list_tb.sv
